### hw/rtl/emission_rate_time_distance_defines.svh
// assertion macros for the emitter rate checker
`ifndef EMISSION_RATE_TIME_DISTANCE_DEFINES_SVH
`define EMISSION_RATE_TIME_DISTANCE_DEFINES_SVH

// same-cycle implication
`define ERTTD_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("emitter check failed");

// next-cycle implication
`define ERTTD_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("emitter check failed");

`endif

### hw/rtl/erttd_pkg.sv
// shared constants and register codes for the emitter rate block
package erttd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_W = 16;
	localparam int POS_W = 32;
	localparam int CNT_W = 16;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int DIST_W = 34;
	localparam int SUM_W = 66;
	localparam int DIV_W = 64;
	localparam int T_W = 31;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [30:0] SPACING_RESET = 31'd65536;

	typedef enum logic [IDX_W-1:0] {
		REG_RATE          = 3'd0,
		REG_SPACING       = 3'd1,
		REG_TELEPORT      = 3'd2,
		REG_MAX_PER_FRAME = 3'd3,
		REG_LOOPING       = 3'd4
	} reg_idx_t;

endpackage

### hw/rtl/erttd_ch_if.sv
// frame and spawn channel interfaces
interface erttd_frame_if import erttd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [DT_W-1:0]         delta_time;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	modport source(output valid, delta_time, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, delta_time, pos_x, pos_y, pos_z, output ready);
endinterface

interface erttd_spawn_if import erttd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CNT_W-1:0]        emit_count;
	logic signed [POS_W-1:0] first_x;
	logic signed [POS_W-1:0] first_y;
	logic signed [POS_W-1:0] first_z;
	logic signed [POS_W-1:0] last_x;
	logic signed [POS_W-1:0] last_y;
	logic signed [POS_W-1:0] last_z;
	modport source(output valid, emit_count, first_x, first_y, first_z,
		last_x, last_y, last_z, input ready);
	modport sink(input valid, emit_count, first_x, first_y, first_z,
		last_x, last_y, last_z, output ready);
endinterface

### hw/rtl/erttd_div.sv
// iterative restoring divider, one quotient bit per cycle
module erttd_div import erttd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_W-1:0]  num,
	input  logic [DIST_W-1:0] den,
	output logic              done,
	output logic [DIV_W-1:0]  quo,
	output logic [DIST_W-1:0] rem
);

	localparam int CW = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_W-1:0]  n_q;
	logic [DIV_W-1:0]  q_q;
	logic [DIST_W-1:0] r_q;
	logic [DIST_W-1:0] d_q;
	logic [DIST_W:0]   r2;
	logic              ge;

	assign r2 = {r_q, n_q[DIV_W-1]};
	assign ge = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_W-2:0], 1'b0};
			q_q <= {q_q[DIV_W-2:0], ge};
			r_q <= ge ? DIST_W'(r2 - {1'b0, d_q}) : r2[DIST_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

### hw/rtl/emission_rate_time_distance.sv
// emitter rate block: spawn count and spawn positions per frame
// frame channel: one beat per rendered frame with delta_time (Q0.16) and
// the emitter world position; ready is high only while the block is idle.
// spawn channel: one beat per frame with emit_count and the first and last spawn
// positions; count 0 means nothing spawned, with zero positions unless one-shot.
// cfg port: write rate, spacing, teleport threshold, per-frame cap and the
// looping bit by index while no frame is in flight.
// processing: a stopped or one-shot frame goes straight to the done state; a
// looping frame runs the 34-step square root and, when the emitter moves, up
// to five passes of the 64-step shared divider; the shared 32x32 multiplier
// has a registered product.
// the next frame is taken as soon as the result is written to the output
// register, so a stalled receiver holds the block only when a second result
// is finished before the first beat is taken.
// reset clears the credit, remainder, previous position, first-frame and
// stop flags and loads the register defaults; only reset leaves one-shot stop.
module emission_rate_time_distance import erttd_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	erttd_frame_if.sink       frame,
	erttd_spawn_if.source     spawn,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int F = FRACTION_BITS;
	localparam int MIN_SPACING = ((1 << F) + 999) / 1000;
	localparam int MIN_MOVE = (1 << F) / 10000;
	localparam int ACC_W = 49;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_DIFF     = 14'b00000000000010,
		S_SQ       = 14'b00000000000100,
		S_SQACC    = 14'b00000000001000,
		S_RATE     = 14'b00000000010000,
		S_SQRT     = 14'b00000000100000,
		S_CLASS    = 14'b00000001000000,
		S_DIVW     = 14'b00000010000000,
		S_COUNT    = 14'b00000100000000,
		S_LASTD    = 14'b00001000000000,
		S_LASTDACC = 14'b00010000000000,
		S_LERP     = 14'b00100000000000,
		S_LERPACC  = 14'b01000000000000,
		S_DONE     = 14'b10000000000000
	} state_t;

	typedef enum logic [2:0] {
		DOP_REM,
		DOP_DCNT,
		DOP_NEWR,
		DOP_T0,
		DOP_T1,
		DOP_TT
	} dop_t;

	state_t state_q;
	dop_t   dop_q;

	logic [31:0]        rate_q;
	logic [30:0]        spacing_cfg_q;
	logic [30:0]        tele_q;
	logic [CNT_W-1:0]   mpf_q;
	logic               loop_q;

	logic [F-1:0]       credit_q;
	logic [31:0]        dr_q;
	logic [POS_W-1:0]   p_q [3];
	logic               has_prev_q;
	logic               stopped_q;

	logic [POS_W-1:0]   w_q [3];
	logic [DT_W-1:0]    dt_q;
	logic [31:0]        m_q [3];
	logic               neg_q [3];
	logic [SUM_W-1:0]   nsum_q;
	logic [SUM_W-1:0]   sx_q;
	logic [SUM_W+1:0]   sres_q;
	logic [SUM_W+1:0]   sbit_q;
	logic [5:0]         step_q;
	logic [DIST_W-1:0]  dist_q;
	logic [CNT_W-1:0]   tcnt_q;
	logic [CNT_W-1:0]   dcnt_q;
	logic [30:0]        spc_q;
	logic [30:0]        remv_q;
	logic [31:0]        firstd_q;
	logic [DIST_W-1:0]  lastd_q;
	logic               moved_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [T_W-1:0]     t0_q;
	logic [T_W-1:0]     t1_q;
	logic [1:0]         ax_q;
	logic               lpass_q;
	logic               lonly_q;
	logic               skip_q;

	logic [CNT_W-1:0]   res_cnt_q;
	logic [POS_W-1:0]   first_q [3];
	logic [POS_W-1:0]   last_q [3];

	logic               ov_q;
	logic [CNT_W-1:0]   o_cnt_q;
	logic [POS_W-1:0]   o_first_q [3];
	logic [POS_W-1:0]   o_last_q [3];

	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod_s1;

	logic               div_go_q;
	logic               div_go_c;
	logic [DIV_W-1:0]   div_num_q;
	logic [DIST_W-1:0]  div_den_q;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIST_W-1:0]  div_rem;

	logic               accept;
	logic [POS_W-1:0]   pos_in [3];
	logic [31:0]        rate_int;
	logic [SUM_W+1:0]   trial;
	logic               take;
	logic [SUM_W+1:0]   sres_nx;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-1:0]   tw;
	logic               tele_c;
	logic               moved_c;
	logic [31:0]        fd_c;
	logic [CNT_W-1:0]   mx_c;
	logic [CNT_W-1:0]   lim_c;
	logic [CNT_W-1:0]   cnt_c;
	logic [DIV_W-1:0]   q_inc;
	logic [63:0]        rnd;
	logic [31:0]        off;
	logic [POS_W-1:0]   lerp_v;
	logic               out_free;

	erttd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign accept    = frame.valid && frame.ready;
	assign frame.ready = (state_q == S_IDLE);
	assign pos_in[0] = frame.pos_x;
	assign pos_in[1] = frame.pos_y;
	assign pos_in[2] = frame.pos_z;
	assign rate_int  = rate_q >> F;
	assign out_free  = !ov_q || spawn.ready;

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = m_q[ax_q];
				mul_b = m_q[ax_q];
			end
			S_RATE: begin
				mul_a = rate_q;
				mul_b = {16'b0, dt_q};
			end
			S_LASTD: begin
				mul_a = {1'b0, spc_q};
				mul_b = {16'b0, CNT_W'(cnt_q - 1'b1)};
			end
			S_LERP: begin
				mul_a = m_q[ax_q];
				mul_b = {1'b0, lpass_q ? t1_q : t0_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
	end

	// square root step, rate product, classification, count and interpolation offset
	always_comb begin
		trial   = sres_q + sbit_q;
		take    = {2'b0, sx_q} >= trial;
		sres_nx = take ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
		acc     = ACC_W'({credit_q, 16'b0}) + ACC_W'(prod_s1[47:0]);
		tw      = acc >> (F + 16);
		tele_c  = (tele_q != '0) && (dist_q > {3'b0, tele_q});
		moved_c = (dist_q > DIST_W'(MIN_MOVE)) && !tele_c;
		fd_c    = {1'b0, spc_q} - {1'b0, div_rem[30:0]};
		mx_c    = (tcnt_q > dcnt_q) ? tcnt_q : dcnt_q;
		lim_c   = (mpf_q > CNT_W'(1)) ? mpf_q : CNT_W'(1);
		cnt_c   = (mx_c > lim_c) ? lim_c : mx_c;
		q_inc   = div_quo + 1'b1;
		rnd     = prod_s1 + 64'(1 << 29);
		off     = rnd[61:30];
		lerp_v  = neg_q[ax_q] ? (p_q[ax_q] - off) : (p_q[ax_q] + off);
	end

	// divider start
	always_comb begin
		div_go_c = 1'b0;
		case (state_q)
			S_CLASS:    div_go_c = moved_c;
			S_DIVW:     div_go_c = div_done && (dop_q inside {DOP_REM, DOP_DCNT, DOP_T0});
			S_COUNT:    div_go_c = (cnt_c != '0) && moved_q && (dcnt_q < tcnt_q);
			S_LASTDACC: div_go_c = 1'b1;
			default:    div_go_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rate_q        <= '0;
			spacing_cfg_q <= SPACING_RESET;
			tele_q        <= '0;
			mpf_q         <= CNT_W'(1);
			loop_q        <= 1'b1;
			credit_q      <= '0;
			dr_q          <= '0;
			p_q[0]        <= '0;
			p_q[1]        <= '0;
			p_q[2]        <= '0;
			has_prev_q    <= 1'b0;
			stopped_q     <= 1'b0;
			ov_q          <= 1'b0;
			div_go_q      <= 1'b0;
			dop_q         <= DOP_REM;
			ax_q          <= '0;
			lpass_q       <= 1'b0;
			lonly_q       <= 1'b0;
			step_q        <= '0;
			skip_q        <= 1'b0;
		end else begin
			div_go_q <= div_go_c;
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE:          rate_q <= cfg_data;
					REG_SPACING:       spacing_cfg_q <= cfg_data[30:0];
					REG_TELEPORT:      tele_q <= cfg_data[30:0];
					REG_MAX_PER_FRAME: mpf_q <= cfg_data[CNT_W-1:0];
					REG_LOOPING:       loop_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && spawn.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						for (int i = 0; i < 3; i++) begin
							w_q[i] <= pos_in[i];
						end
						dt_q  <= frame.delta_time;
						spc_q <= (spacing_cfg_q > 31'(MIN_SPACING)) ? spacing_cfg_q
							: 31'(MIN_SPACING);
						if (stopped_q) begin
							skip_q    <= 1'b1;
							res_cnt_q <= '0;
							for (int i = 0; i < 3; i++) begin
								first_q[i] <= '0;
								last_q[i]  <= '0;
							end
							state_q <= S_DONE;
						end else begin
							skip_q <= 1'b0;
							if (!has_prev_q) begin
								for (int i = 0; i < 3; i++) begin
									p_q[i] <= pos_in[i];
								end
							end
							if (!loop_q) begin
								res_cnt_q <= (rate_int > 32'(COUNT_MAX)) ? COUNT_MAX
									: rate_int[CNT_W-1:0];
								for (int i = 0; i < 3; i++) begin
									first_q[i] <= pos_in[i];
									last_q[i]  <= pos_in[i];
								end
								stopped_q <= 1'b1;
								state_q   <= S_DONE;
							end else begin
								state_q <= S_DIFF;
							end
						end
					end
				end
				S_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						logic [32:0] d;
						d = {w_q[i][31], w_q[i]} - {p_q[i][31], p_q[i]};
						neg_q[i] <= d[32];
						m_q[i]   <= d[32] ? 32'(-d) : d[31:0];
					end
					nsum_q  <= '0;
					ax_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_SQACC;
				end
				S_SQACC: begin
					nsum_q <= nsum_q + {2'b0, prod_s1};
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_RATE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_SQ;
					end
				end
				S_RATE: begin
					sx_q    <= nsum_q;
					sres_q  <= '0;
					sbit_q  <= (SUM_W+2)'(1) << SUM_W;
					step_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (step_q == '0) begin
						credit_q <= acc[F+15:16];
						tcnt_q   <= (tw > ACC_W'(COUNT_MAX)) ? COUNT_MAX : tw[CNT_W-1:0];
					end
					if (take) begin
						sx_q <= sx_q - trial[SUM_W-1:0];
					end
					sres_q <= sres_nx;
					sbit_q <= sbit_q >> 2;
					step_q <= step_q + 1'b1;
					if (step_q == 6'(DIST_W - 1)) begin
						dist_q  <= sres_nx[DIST_W-1:0];
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					moved_q <= moved_c;
					dcnt_q  <= '0;
					if (tele_c) begin
						dr_q <= '0;
					end
					if (moved_c) begin
						div_num_q <= DIV_W'(dr_q);
						div_den_q <= DIST_W'(spc_q);
						dop_q     <= DOP_REM;
						state_q   <= S_DIVW;
					end else begin
						state_q <= S_COUNT;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						case (dop_q)
							DOP_REM: begin
								remv_q   <= div_rem[30:0];
								firstd_q <= fd_c;
								div_den_q <= DIST_W'(spc_q);
								if (DIST_W'(fd_c) <= dist_q) begin
									div_num_q <= DIV_W'(dist_q - DIST_W'(fd_c));
									dop_q     <= DOP_DCNT;
								end else begin
									div_num_q <= DIV_W'(35'(div_rem[30:0]) + 35'(dist_q));
									dop_q     <= DOP_NEWR;
								end
							end
							DOP_DCNT: begin
								dcnt_q <= (div_quo >= DIV_W'(COUNT_MAX)) ? COUNT_MAX
									: q_inc[CNT_W-1:0];
								div_den_q <= DIST_W'(spc_q);
								div_num_q <= DIV_W'(35'(remv_q) + 35'(dist_q));
								dop_q     <= DOP_NEWR;
							end
							DOP_NEWR: begin
								dr_q    <= div_rem[31:0];
								state_q <= S_COUNT;
							end
							DOP_T0: begin
								t0_q      <= div_quo[T_W-1:0];
								div_den_q <= dist_q;
								div_num_q <= DIV_W'(lastd_q) << 30;
								dop_q     <= DOP_T1;
							end
							DOP_T1: begin
								t1_q    <= div_quo[T_W-1:0];
								ax_q    <= '0;
								lpass_q <= 1'b0;
								state_q <= S_LERP;
							end
							DOP_TT: begin
								t0_q    <= div_quo[T_W-1:0];
								ax_q    <= '0;
								lpass_q <= 1'b0;
								state_q <= S_LERP;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_COUNT: begin
					cnt_q     <= cnt_c;
					res_cnt_q <= cnt_c;
					lonly_q   <= 1'b0;
					if (cnt_c == '0) begin
						for (int i = 0; i < 3; i++) begin
							first_q[i] <= '0;
							last_q[i]  <= '0;
						end
						state_q <= S_DONE;
					end else if (moved_q && (dcnt_q >= tcnt_q)) begin
						state_q <= S_LASTD;
					end else if (moved_q) begin
						lonly_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							last_q[i] <= w_q[i];
						end
						div_num_q <= DIV_W'(1) << 30;
						div_den_q <= DIST_W'(cnt_c);
						dop_q     <= DOP_TT;
						state_q   <= S_DIVW;
					end else begin
						for (int i = 0; i < 3; i++) begin
							first_q[i] <= w_q[i];
							last_q[i]  <= w_q[i];
						end
						state_q <= S_DONE;
					end
				end
				S_LASTD: begin
					state_q <= S_LASTDACC;
				end
				S_LASTDACC: begin
					lastd_q   <= DIST_W'(firstd_q) + prod_s1[DIST_W-1:0];
					div_num_q <= DIV_W'(firstd_q) << 30;
					div_den_q <= dist_q;
					dop_q     <= DOP_T0;
					state_q   <= S_DIVW;
				end
				S_LERP: begin
					state_q <= S_LERPACC;
				end
				S_LERPACC: begin
					if (lpass_q) begin
						last_q[ax_q] <= lerp_v;
					end else begin
						first_q[ax_q] <= lerp_v;
					end
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						if (!lpass_q && !lonly_q) begin
							lpass_q <= 1'b1;
							state_q <= S_LERP;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_LERP;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (!skip_q) begin
							for (int i = 0; i < 3; i++) begin
								p_q[i] <= w_q[i];
							end
							has_prev_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_cnt_q <= res_cnt_q;
			for (int i = 0; i < 3; i++) begin
				o_first_q[i] <= first_q[i];
				o_last_q[i]  <= last_q[i];
			end
		end
	end

	assign spawn.valid      = ov_q;
	assign spawn.emit_count = o_cnt_q;
	assign spawn.first_x    = o_first_q[0];
	assign spawn.first_y    = o_first_q[1];
	assign spawn.first_z    = o_first_q[2];
	assign spawn.last_x     = o_last_q[0];
	assign spawn.last_y     = o_last_q[1];
	assign spawn.last_z     = o_last_q[2];

endmodule

### hw/rtl/erttd_chk.sv
// port checker for the emitter rate block, bound to the top level
`include "emission_rate_time_distance_defines.svh"

module erttd_chk import erttd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] emit_count
);

	`ERTTD_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(emit_count))
	`ERTTD_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
	`ERTTD_NOW(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind emission_rate_time_distance erttd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame.valid),
	.in_ready  (frame.ready),
	.out_valid (spawn.valid),
	.out_ready (spawn.ready),
	.emit_count(spawn.emit_count)
);
